// File: rtl/vhde_pkg.sv
// ----------------------------------------------------------------------------
// vhde_pkg
// Shared types and constants of the video DMA descriptor engine.
// ----------------------------------------------------------------------------
package vhde_pkg;

  // Bus command codes
  localparam logic [2:0] CMD_SRC_HI = 3'd0;
  localparam logic [2:0] CMD_SRC_LO = 3'd1;
  localparam logic [2:0] CMD_DST_HI = 3'd2;
  localparam logic [2:0] CMD_DST_LO = 3'd3;
  localparam logic [2:0] CMD_CTRL   = 3'd4;
  localparam logic [2:0] CMD_TICK   = 3'd5;
  localparam logic [2:0] CMD_OAM    = 3'd6;

  // Burst sizes and address constants
  localparam int unsigned BlockBytes = 16;
  localparam int unsigned OamBytes   = 160;
  localparam logic [15:0] SRC_MASK   = 16'hFFF0;
  localparam logic [15:0] DST_MASK   = 16'h1FF0;
  localparam logic [15:0] VRAM_BASE  = 16'h8000;
  localparam logic [15:0] OAM_BASE   = 16'hFE00;
  localparam logic [7:0]  CTRL_IDLE  = 8'hFF;
  localparam logic [11:0] BLOCK_LEN  = 12'(BlockBytes);
  localparam logic [11:0] OAM_LEN    = 12'(OamBytes);

  // Command queue between front and back end
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Classified operation
  typedef enum logic [2:0] {
    OP_NOP,
    OP_SRC_HI,
    OP_SRC_LO,
    OP_DST_HI,
    OP_DST_LO,
    OP_CTRL,
    OP_TICK,
    OP_OAM
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  data;
    logic [11:0] gp_len;  // general-purpose burst length, if the op is a control write
  } op_t;

endpackage

// File: rtl/vhde_front.sv
// ----------------------------------------------------------------------------
// vhde_front
// Classifies bus commands and precomputes the general-purpose burst length.
// ----------------------------------------------------------------------------
module vhde_front (
  input  logic [2:0]     command_i,
  input  logic [7:0]     write_data_i,
  output vhde_pkg::op_t  op_o
);
  import vhde_pkg::*;

  op_e op;

  // Command decode, unused code becomes a no-op
  always_comb begin
    unique case (command_i)
      CMD_SRC_HI: op = OP_SRC_HI;
      CMD_SRC_LO: op = OP_SRC_LO;
      CMD_DST_HI: op = OP_DST_HI;
      CMD_DST_LO: op = OP_DST_LO;
      CMD_CTRL:   op = OP_CTRL;
      CMD_TICK:   op = OP_TICK;
      CMD_OAM:    op = OP_OAM;
      default:    op = OP_NOP;
    endcase
  end

  // Length is (blocks + 1) * 16; at most 2048, fits 12 bits
  assign op_o.op     = op;
  assign op_o.data   = write_data_i;
  assign op_o.gp_len = {({1'b0, write_data_i[6:0]} + 8'd1), 4'b0000};

endmodule

// File: rtl/vhde_queue.sv
// ----------------------------------------------------------------------------
// vhde_queue
// Short FIFO of classified operations between front and back end.
// ----------------------------------------------------------------------------
module vhde_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  vhde_pkg::op_t  push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output vhde_pkg::op_t  pop_data_o
);
  import vhde_pkg::*;

  op_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != QCntW'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/vhde_exec.sv
// ----------------------------------------------------------------------------
// vhde_exec
// Back end: holds the DMA registers, executes one operation per cycle unless
// the output register is held, and registers the resulting descriptor.
// ----------------------------------------------------------------------------
module vhde_exec (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  output logic           op_ready_o,
  input  vhde_pkg::op_t  op_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           copy_valid_o,
  output logic [15:0]    copy_src_o,
  output logic [15:0]    copy_dst_o,
  output logic [11:0]    copy_len_o,
  output logic           hdma_active_o,
  output logic [7:0]     control_value_o
);
  import vhde_pkg::*;

  // Architectural state
  logic [7:0]  src_hi_q, src_hi_d, src_lo_q, src_lo_d;
  logic [7:0]  dst_hi_q, dst_hi_d, dst_lo_q, dst_lo_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [15:0] run_src_q, run_src_d, run_dst_q, run_dst_d;

  // Output register
  logic        out_valid_q;
  logic        cv_q, cv_d;
  logic [15:0] csrc_q, csrc_d, cdst_q, cdst_d;
  logic [11:0] clen_q, clen_d;

  logic        fire, idle, near_end;
  logic [15:0] src_addr, dst_off, gp_src_nxt, gp_dst_nxt, tk_src_nxt, tk_dst_nxt;

  assign op_ready_o = !out_valid_q || out_ready_i;
  assign fire       = op_valid_i && op_ready_o;

  assign idle       = ctrl_q[7];
  assign src_addr   = {src_hi_q, src_lo_q} & SRC_MASK;
  assign dst_off    = {dst_hi_q, dst_lo_q} & DST_MASK;
  assign gp_src_nxt = src_addr + {4'b0, op_i.gp_len};
  assign gp_dst_nxt = dst_off + {4'b0, op_i.gp_len};
  assign tk_src_nxt = run_src_q + 16'(BlockBytes);
  assign tk_dst_nxt = run_dst_q + 16'(BlockBytes);
  // run_dst + 16 would pass 0xFFFF
  assign near_end   = &run_dst_q[15:4];

  // Operation execute
  always_comb begin
    src_hi_d  = src_hi_q;
    src_lo_d  = src_lo_q;
    dst_hi_d  = dst_hi_q;
    dst_lo_d  = dst_lo_q;
    ctrl_d    = ctrl_q;
    run_src_d = run_src_q;
    run_dst_d = run_dst_q;
    cv_d      = 1'b0;
    csrc_d    = '0;
    cdst_d    = '0;
    clen_d    = '0;
    unique case (op_i.op)
      OP_SRC_HI: src_hi_d = op_i.data;
      OP_SRC_LO: src_lo_d = op_i.data;
      OP_DST_HI: dst_hi_d = op_i.data;
      OP_DST_LO: dst_lo_d = op_i.data;
      OP_CTRL: begin
        if (idle) begin
          if (op_i.data[7]) begin
            // arm H-blank mode
            ctrl_d    = {1'b0, op_i.data[6:0]};
            run_src_d = src_addr;
            run_dst_d = dst_off;
          end else begin
            // general-purpose burst
            cv_d     = 1'b1;
            csrc_d   = src_addr;
            cdst_d   = VRAM_BASE + dst_off;
            clen_d   = op_i.gp_len;
            src_hi_d = gp_src_nxt[15:8];
            src_lo_d = gp_src_nxt[7:0];
            dst_hi_d = gp_dst_nxt[15:8];
            dst_lo_d = gp_dst_nxt[7:0];
            ctrl_d   = CTRL_IDLE;
          end
        end else if (!op_i.data[7]) begin
          // cancel armed transfer
          ctrl_d = ctrl_q | 8'h80;
        end
      end
      OP_TICK: begin
        if (!idle) begin
          if (near_end) begin
            ctrl_d = ctrl_q | 8'h80;
          end else begin
            cv_d      = 1'b1;
            csrc_d    = run_src_q;
            cdst_d    = VRAM_BASE + run_dst_q;
            clen_d    = BLOCK_LEN;
            run_src_d = tk_src_nxt;
            run_dst_d = tk_dst_nxt;
            src_hi_d  = tk_src_nxt[15:8];
            src_lo_d  = tk_src_nxt[7:0];
            dst_hi_d  = tk_dst_nxt[15:8];
            dst_lo_d  = tk_dst_nxt[7:0];
            ctrl_d    = ctrl_q - 8'd1;
          end
        end
      end
      OP_OAM: begin
        cv_d   = 1'b1;
        csrc_d = {op_i.data, 8'h00};
        cdst_d = OAM_BASE;
        clen_d = OAM_LEN;
      end
      default: ;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_hi_q    <= '0;
      src_lo_q    <= '0;
      dst_hi_q    <= '0;
      dst_lo_q    <= '0;
      ctrl_q      <= CTRL_IDLE;
      run_src_q   <= '0;
      run_dst_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        src_hi_q  <= src_hi_d;
        src_lo_q  <= src_lo_d;
        dst_hi_q  <= dst_hi_d;
        dst_lo_q  <= dst_lo_d;
        ctrl_q    <= ctrl_d;
        run_src_q <= run_src_d;
        run_dst_q <= run_dst_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, control value taken after the update
  logic [7:0] cval_q;
  always_ff @(posedge clk_i) begin
    if (fire) begin
      cv_q   <= cv_d;
      csrc_q <= csrc_d;
      cdst_q <= cdst_d;
      clen_q <= clen_d;
      cval_q <= ctrl_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign copy_valid_o    = cv_q;
  assign copy_src_o      = csrc_q;
  assign copy_dst_o      = cdst_q;
  assign copy_len_o      = clen_q;
  assign control_value_o = cval_q;
  assign hdma_active_o   = !cval_q[7];

endmodule

// File: rtl/vram_hdma_descriptor_engine_unit.sv
// ----------------------------------------------------------------------------
// vram_hdma_descriptor_engine_unit
// Video DMA register block emitting copy descriptors for VRAM and OAM DMA.
// ----------------------------------------------------------------------------
// Takes one bus command per cycle while in_ready_o is high (byte register
// write, control write, H-blank tick or OAM trigger) and returns one result
// per command: an optional copy descriptor plus the updated control
// register. A command is classified on entry and parked in a two-entry
// queue; the back end executes one queued command per cycle into an output
// register, so each result passes through the queue and the output register.
// Results leave at a sustained one per cycle while out_ready_i is held high.
module vram_hdma_descriptor_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        copy_valid_o,
  output logic [15:0] copy_src_o,
  output logic [15:0] copy_dst_o,
  output logic [11:0] copy_len_o,
  output logic        hdma_active_o,
  output logic [7:0]  control_value_o
);
  import vhde_pkg::*;

  op_t  front_op, q_op;
  logic q_valid, q_ready;

  // Front end: classify
  vhde_front u_front (
    .command_i    (command_i),
    .write_data_i (write_data_i),
    .op_o         (front_op)
  );

  // Decoupling queue
  vhde_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_op),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_op)
  );

  // Back end: execute
  vhde_exec u_exec (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_valid_i      (q_valid),
    .op_ready_o      (q_ready),
    .op_i            (q_op),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .copy_valid_o    (copy_valid_o),
    .copy_src_o      (copy_src_o),
    .copy_dst_o      (copy_dst_o),
    .copy_len_o      (copy_len_o),
    .hdma_active_o   (hdma_active_o),
    .control_value_o (control_value_o)
  );

`ifndef SYNTH
  // No descriptor means all descriptor fields are zero
  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !copy_valid_o |->
      copy_src_o == 16'h0 && copy_dst_o == 16'h0 && copy_len_o == 12'h0)
    else $error("descriptor fields set without a burst");

  // Every burst length is a whole number of blocks, never empty nor over 2 KiB
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && copy_valid_o |->
      copy_len_o != 12'h0 && copy_len_o <= 12'd2048 && copy_len_o[3:0] == 4'h0)
    else $error("burst length out of range");

  // Active flag mirrors the idle bit of the control register
  a_active_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hdma_active_o == !control_value_o[7])
    else $error("active flag disagrees with control register");

  // An OAM burst always targets OAM with its fixed length
  a_oam_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && copy_valid_o && copy_dst_o == OAM_BASE |->
      copy_len_o == OAM_LEN && copy_src_o[7:0] == 8'h00)
    else $error("malformed OAM burst");
`endif

endmodule
